// ----- rtl/core/two_level_session_id_allocator_macros.svh -----
// Assertion macros for the session id allocator
`ifndef TWO_LEVEL_SESSION_ID_ALLOCATOR_MACROS_SVH
`define TWO_LEVEL_SESSION_ID_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define TLSIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define TLSIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- rtl/core/tlsia_pkg.sv -----
// Types, constants and helpers for the session id allocator
`timescale 1ns / 1ps
package tlsia_pkg;

    localparam int PAGE_BITS = 7;
    localparam int SLOT_BITS = 9;
    localparam int ID_BITS   = 16;
    localparam int HANDLE_W  = 32;
    localparam int PAGE_MAX  = 1 << PAGE_BITS;
    localparam int SLOT_MAX  = 1 << SLOT_BITS;

    typedef logic [PAGE_BITS-1:0]           page_idx_t;
    typedef logic [PAGE_BITS:0]             page_ref_t;
    typedef logic [SLOT_BITS-1:0]           slot_idx_t;
    typedef logic [SLOT_BITS:0]             slot_ref_t;
    typedef logic [PAGE_BITS+SLOT_BITS-1:0] cell_t;
    typedef logic [HANDLE_W-1:0]            handle_t;

    typedef struct packed {
        logic      present;
        slot_ref_t use_cnt;
        slot_ref_t fhead;
        page_ref_t nxt;
        slot_ref_t fill;     // slots at or above this are still in their fresh state
    } page_ent_t;

    typedef struct packed {
        slot_ref_t nxt;
        handle_t   holder;
    } slot_ent_t;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_MISMATCH  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SL,
        S_EXE,
        S_NX,
        S_DONE
    } state_t;

    function automatic page_ent_t page_reset(input page_idx_t p);
        page_ent_t e;
        if (p == '0) begin
            e.present = 1'b1;
            e.use_cnt = slot_ref_t'(1);
            e.fhead   = slot_ref_t'(1);
            e.nxt     = page_ref_t'(1);
            e.fill    = slot_ref_t'(1);
        end
        else begin
            e.present = 1'b0;
            e.use_cnt = '0;
            e.fhead   = '0;
            e.nxt     = page_ref_t'({1'b0, p} + 1'b1);
            e.fill    = '0;
        end
        return e;
    endfunction

endpackage

// ----- rtl/core/two_level_session_id_allocator.sv -----
// Two-level session id allocator: page list and per-page slot lists in memory
`timescale 1ns / 1ps
// An item (add, remove or find) runs through page read, slot read, write-back
// and result; a remove that makes a full page rejoin the page list also reads
// the old list head for retirement before the result, and items that fail on
// their inputs alone go straight to the result. The order is set by the chain
// of dependent reads through the page and slot memories. One item is worked
// at a time; a finished result waits in the output register while the next
// item is accepted. Pages carry valid bits, and a fill mark per page stands
// in for rebuilding the slot chain, so no clearing pass is run.
module two_level_session_id_allocator
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic [31:0]               handle,
    input  logic [tlsia_pkg::ID_BITS-1:0] id_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic [tlsia_pkg::ID_BITS-1:0] id_out,
    output logic [31:0]               handle_out
);
    import tlsia_pkg::*;

    `include "two_level_session_id_allocator_macros.svh"

    state_t    state_reg, state_next;
    cmd_t      cmd_reg;
    handle_t   handle_reg;
    page_idx_t pg_reg, pg_next;
    slot_ref_t sl_reg, sl_next;
    page_ref_t head_reg, head_next;
    page_ent_t pw_reg, pw_next;
    logic      [PAGE_MAX-1:0] pv_reg;

    status_t   res_st_reg, res_st_next;
    cell_t     res_id_reg, res_id_next;
    handle_t   res_h_reg, res_h_next;

    logic      out_valid_reg;
    status_t   status_reg;
    cell_t     id_out_reg;
    handle_t   hout_reg;

    // page memory
    page_ent_t page_mem [PAGE_MAX];
    page_ent_t pg_rdata_reg;
    page_idx_t pg_addr_reg;
    logic      pg_re, pg_we;
    page_idx_t pg_raddr, pg_waddr;
    page_ent_t pg_wdata;
    page_ent_t pe;

    // slot memory
    slot_ent_t slot_mem [PAGE_MAX*SLOT_MAX];
    slot_ent_t sl_rdata_reg;
    logic      sl_re, sl_we;
    cell_t     sl_raddr, sl_waddr;
    slot_ent_t sl_wdata;
    slot_ent_t se;

    page_ent_t built;
    slot_ref_t use_dec;
    logic      fresh;
    logic      accept;
    logic      early_done;
    logic      go_exe;
    logic      go_nx;
    logic      out_free;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign pe       = pv_reg[pg_addr_reg] ? pg_rdata_reg : page_reset(pg_addr_reg);
    assign fresh    = (sl_reg >= pw_reg.fill) || ((pg_reg == '0) && (sl_reg == '0));
    assign use_dec  = pw_reg.use_cnt - 1'b1;

    always_comb
    begin
        se = sl_rdata_reg;
        if (fresh)
        begin
            se.nxt    = slot_ref_t'(sl_reg + 1'b1);
            se.holder = '0;
        end
    end

    always_comb
    begin
        built = pe;
        if (!pe.present)
        begin
            built.present = 1'b1;
            built.use_cnt = '0;
            built.fhead   = '0;
            built.fill    = '0;
        end
    end

    // datapath and memory control
    always_comb
    begin
        pg_re       = 1'b0;
        pg_raddr    = pg_reg;
        pg_we       = 1'b0;
        pg_waddr    = pg_reg;
        pg_wdata    = pw_reg;
        sl_re       = 1'b0;
        sl_raddr    = {pg_reg, sl_reg[SLOT_BITS-1:0]};
        sl_we       = 1'b0;
        sl_waddr    = {pg_reg, sl_reg[SLOT_BITS-1:0]};
        sl_wdata    = se;
        head_next   = head_reg;
        pw_next     = pw_reg;
        pg_next     = pg_reg;
        sl_next     = sl_reg;
        res_st_next = res_st_reg;
        res_id_next = res_id_reg;
        res_h_next  = res_h_reg;
        early_done  = 1'b0;
        go_exe      = 1'b0;
        go_nx       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                res_st_next = ST_OK;
                res_id_next = '0;
                res_h_next  = '0;
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_ADD:
                        begin
                            if (handle == '0)
                            begin
                                res_st_next = ST_MISMATCH;
                                early_done  = 1'b1;
                            end
                            else if (head_reg[PAGE_BITS])
                            begin
                                res_st_next = ST_LIMIT;
                                early_done  = 1'b1;
                            end
                            else
                            begin
                                pg_next  = head_reg[PAGE_BITS-1:0];
                                pg_re    = 1'b1;
                                pg_raddr = head_reg[PAGE_BITS-1:0];
                            end
                        end
                        CMD_REMOVE, CMD_FIND:
                        begin
                            pg_next  = id_in[ID_BITS-1:SLOT_BITS];
                            sl_next  = {1'b0, id_in[SLOT_BITS-1:0]};
                            pg_re    = 1'b1;
                            pg_raddr = id_in[ID_BITS-1:SLOT_BITS];
                        end
                        default:
                        begin
                            early_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SL:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    pw_next = built;
                    sl_next = built.fhead;
                    if (built.fhead[SLOT_BITS])
                    begin
                        // head page has no free slot: keep any rebuild, report limit
                        pg_we       = 1'b1;
                        pg_wdata    = built;
                        res_st_next = ST_LIMIT;
                    end
                    else
                    begin
                        sl_re    = 1'b1;
                        sl_raddr = {pg_reg, built.fhead[SLOT_BITS-1:0]};
                        go_exe   = 1'b1;
                    end
                end
                else
                begin
                    pw_next = pe;
                    sl_re   = 1'b1;
                    go_exe  = 1'b1;
                end
            end
            S_EXE:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        sl_we           = 1'b1;
                        sl_wdata.nxt    = slot_ref_t'(SLOT_MAX);
                        sl_wdata.holder = handle_reg;
                        pw_next.use_cnt = pw_reg.use_cnt + 1'b1;
                        pw_next.fhead   = se.nxt;
                        if (sl_reg == pw_reg.fill)
                        begin
                            pw_next.fill = pw_reg.fill + 1'b1;
                        end
                        if (se.nxt == slot_ref_t'(SLOT_MAX))
                        begin
                            head_next   = pw_reg.nxt;
                            pw_next.nxt = page_ref_t'(PAGE_MAX);
                        end
                        pg_we       = 1'b1;
                        pg_wdata    = pw_next;
                        res_id_next = {pg_reg, sl_reg[SLOT_BITS-1:0]};
                    end
                    CMD_REMOVE:
                    begin
                        if (!pw_reg.present)
                        begin
                            res_st_next = ST_NOT_FOUND;
                        end
                        else if (handle_reg == '0 || se.holder != handle_reg)
                        begin
                            res_st_next = ST_MISMATCH;
                        end
                        else
                        begin
                            sl_we           = 1'b1;
                            sl_wdata.nxt    = pw_reg.fhead;
                            sl_wdata.holder = '0;
                            pw_next.use_cnt = use_dec;
                            pw_next.fhead   = sl_reg;
                            if (use_dec == slot_ref_t'(SLOT_MAX - 1))
                            begin
                                // page was full: rejoin list, old head may retire
                                pw_next.nxt = head_reg;
                                head_next   = {1'b0, pg_reg};
                                if (!head_reg[PAGE_BITS])
                                begin
                                    pg_re    = 1'b1;
                                    pg_raddr = head_reg[PAGE_BITS-1:0];
                                    go_nx    = 1'b1;
                                end
                            end
                            else if (pg_reg != '0 && use_dec == '0
                                     && head_reg != {1'b0, pg_reg})
                            begin
                                pw_next.present = 1'b0;
                                pw_next.fhead   = '0;
                            end
                            pg_we    = 1'b1;
                            pg_wdata = pw_next;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (!pw_reg.present || se.holder == '0)
                        begin
                            res_st_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            res_h_next = se.holder;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_NX:
            begin
                if (pe.present && pe.use_cnt == '0 && pg_addr_reg != '0
                    && pg_addr_reg != pg_reg)
                begin
                    pg_we         = 1'b1;
                    pg_waddr      = pg_addr_reg;
                    pg_wdata      = pe;
                    pg_wdata.present = 1'b0;
                    pg_wdata.fhead   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = early_done ? S_DONE : S_SL;
                end
            end
            S_SL:   state_next = go_exe ? S_EXE : S_DONE;
            S_EXE:  state_next = go_nx ? S_NX : S_DONE;
            S_NX:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        out_valid  = out_valid_reg;
        status     = status_reg;
        id_out     = id_out_reg;
        handle_out = hout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            pv_reg        <= '0;
            pg_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            if (pg_we)
            begin
                pv_reg[pg_waddr] <= 1'b1;
            end
            if (pg_re)
            begin
                pg_addr_reg <= pg_raddr;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(cmd);
            handle_reg <= handle;
        end
        pg_reg     <= pg_next;
        sl_reg     <= sl_next;
        pw_reg     <= pw_next;
        res_st_reg <= res_st_next;
        res_id_reg <= res_id_next;
        res_h_reg  <= res_h_next;
        if (state_reg == S_DONE && out_free)
        begin
            status_reg <= res_st_reg;
            id_out_reg <= res_id_reg;
            hout_reg   <= res_h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
        begin
            page_mem[pg_waddr] <= pg_wdata;
        end
        if (pg_re)
        begin
            pg_rdata_reg <= page_mem[pg_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            slot_mem[sl_waddr] <= sl_wdata;
        end
        if (sl_re)
        begin
            sl_rdata_reg <= slot_mem[sl_raddr];
        end
    end

    `TLSIA_ASSERT_IMP(a_head_range, clk, rst_n, 1'b1, head_reg <= page_ref_t'(PAGE_MAX))
    `TLSIA_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_reg == S_IDLE, !pg_we && !sl_we)
    `TLSIA_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_reg != S_IDLE)

endmodule
